// ===== design/bffa_pkg.sv =====
package bffa_pkg;

    // Default pool size, in blocks.
    localparam int NUM_BLOCKS_DEF = 256;

    // Fixed widths of the request and result fields.
    localparam int BLOCK_COUNT_W = 9;
    localparam int START_BLOCK_W = 8;
    localparam int BLOCKS_LEFT_W = 9;

endpackage

// ===== design/bitmap_first_fit_allocator_unit.sv =====
// A request for zero blocks, or for more blocks than the pool holds, is answered in the cycle
// after it is taken. Any other request is answered after the scan pass on failure, and after the
// scan pass and the mark pass on success.
// A new request is taken only while idle. The used map turns through a one-bit scan position once
// to search and once more to mark the run. After a pass, busy falls as the result strobe rises; no stalls.
// Reset (synchronous, active low) frees every block and clears the start map at once.
module bitmap_first_fit_allocator_unit #(
    parameter int NUM_BLOCKS = bffa_pkg::NUM_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bffa_pkg::BLOCK_COUNT_W-1:0] i_block_count,
    output logic                              o_strobe,
    output logic                              o_granted,
    output logic [bffa_pkg::START_BLOCK_W-1:0] o_start_block,
    output logic [bffa_pkg::BLOCKS_LEFT_W-1:0] o_blocks_left
);
    import bffa_pkg::*;

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MARK = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [NUM_BLOCKS-1:0]    r_used, n_used;
    logic [NUM_BLOCKS-1:0]    r_start_map, n_start_map;
    logic [CW-1:0]            r_free, n_free;
    logic [IW-1:0]            r_idx, n_idx;
    logic [BLOCK_COUNT_W-1:0] r_len, n_len;
    logic [BLOCK_COUNT_W-1:0] r_run, n_run;
    logic [BLOCK_COUNT_W-1:0] r_rem, n_rem;
    logic [IW-1:0]            r_begin, n_begin;
    logic [IW-1:0]            r_first, n_first;
    logic                     r_found, n_found;
    logic                     r_strobe, n_strobe;
    logic                     r_granted, n_granted;
    logic [IW-1:0]            r_res_start, n_res_start;

    logic                     bit_used;
    logic                     mark;
    logic                     at_first;
    logic                     len_bad;
    logic [BLOCK_COUNT_W-1:0] run_inc;

    assign bit_used = r_used[0];
    assign at_first = (r_idx == r_first);
    assign mark     = (r_state == ST_MARK) && (at_first || (r_rem != '0));
    assign run_inc  = r_run + BLOCK_COUNT_W'(1);
    assign len_bad  = (i_block_count == '0) || (32'(i_block_count) > NUM_BLOCKS);

    // Next-state logic: rotate the maps one block per cycle while scanning or marking.
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_start_map = r_start_map;
        n_free      = r_free;
        n_idx       = r_idx;
        n_len       = r_len;
        n_run       = r_run;
        n_rem       = r_rem;
        n_begin     = r_begin;
        n_first     = r_first;
        n_found     = r_found;
        n_strobe    = 1'b0;
        n_granted   = r_granted;
        n_res_start = r_res_start;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_len   = i_block_count;
                    n_idx   = '0;
                    n_run   = '0;
                    n_found = 1'b0;
                    if (len_bad) begin
                        // Zero or oversized request fails without a scan.
                        n_strobe    = 1'b1;
                        n_granted   = 1'b0;
                        n_res_start = '0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_used      = {r_used[0], r_used[NUM_BLOCKS-1:1]};
                n_start_map = {r_start_map[0], r_start_map[NUM_BLOCKS-1:1]};
                n_idx       = r_idx + IW'(1);
                // Track the current free run until the first one long enough shows up.
                if (!r_found) begin
                    if (bit_used) begin
                        n_run = '0;
                    end else begin
                        n_run = run_inc;
                        if (r_run == '0) begin
                            n_begin = r_idx;
                        end
                        if (run_inc == r_len) begin
                            n_found = 1'b1;
                            n_first = (r_run == '0) ? r_idx : r_begin;
                        end
                    end
                end
                // A run that completes on the top block still counts as found.
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    n_rem = '0;
                    if (n_found) begin
                        n_state = ST_MARK;
                    end else begin
                        n_state     = ST_IDLE;
                        n_strobe    = 1'b1;
                        n_granted   = 1'b0;
                        n_res_start = '0;
                    end
                end
            end
            ST_MARK: begin
                n_used      = {r_used[0] | mark, r_used[NUM_BLOCKS-1:1]};
                n_start_map = {r_start_map[0] | at_first, r_start_map[NUM_BLOCKS-1:1]};
                n_idx       = r_idx + IW'(1);
                // The run counter reloads at its first block and counts down the rest.
                if (mark) begin
                    n_rem = (at_first ? r_len : r_rem) - BLOCK_COUNT_W'(1);
                end
                if (r_idx == LAST_IDX) begin
                    n_idx       = '0;
                    n_state     = ST_IDLE;
                    n_strobe    = 1'b1;
                    n_granted   = 1'b1;
                    n_res_start = r_first;
                    n_free      = (32'(r_free) >= 32'(r_len)) ? r_free - CW'(r_len) : '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and both maps are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_start_map <= '0;
            r_free      <= CW'(NUM_BLOCKS);
            r_idx       <= '0;
            r_rem       <= '0;
            r_found     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_start_map <= n_start_map;
            r_free      <= n_free;
            r_idx       <= n_idx;
            r_rem       <= n_rem;
            r_found     <= n_found;
            r_strobe    <= n_strobe;
        end
    end

    // Working payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_run       <= n_run;
        r_begin     <= n_begin;
        r_first     <= n_first;
        r_granted   <= n_granted;
        r_res_start <= n_res_start;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_granted     = r_granted;
    assign o_start_block = START_BLOCK_W'(r_res_start);
    assign o_blocks_left = BLOCKS_LEFT_W'(r_free);

    // Marking happens only after a run was found.
    a_mark_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MARK |-> r_found)
        else $error("mark pass without a found run");

    // The free count never exceeds the pool size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= NUM_BLOCKS)
        else $error("free count above pool size");

    // The mark countdown is spent whenever the block is idle.
    a_rem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_rem == '0)
        else $error("mark countdown left over");

    // A result follows either a pass over the map or a request taken while idle.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(r_state) != ST_IDLE) || $past(start))
        else $error("result strobe without a request");

endmodule
